@@ rtl/tios_pkg.sv @@
// ----------------------------------------------------------------------------
// tios_pkg
// Shared types and constants for the tile interval overlap scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package tios_pkg;

  localparam int TILE_DEPTH = 64;
  localparam int IDX_W      = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TILE_DEPTH + 1);

  localparam int CMD_W   = 2;
  localparam int CHROM_W = 5;
  localparam int DS_W    = 20;
  localparam int POS_W   = 32;
  localparam int NUM_W   = 6;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic [DS_W-1:0]  dataset;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
  } rec_t;

  typedef struct packed {
    logic               found;
    rec_t               rec;
    logic [CHROM_W-1:0] chrom;
    logic [NUM_W-1:0]   number;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/tios_if.sv @@
// ----------------------------------------------------------------------------
// tios_in_if / tios_out_if
// Valid/ready channels for command transactions and hit transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tios_in_if import tios_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [CHROM_W-1:0] tile_chrom;
  logic [DS_W-1:0]    record_dataset;
  logic [POS_W-1:0]   record_start;
  logic [POS_W-1:0]   record_end;
  logic [POS_W-1:0]   query_start;
  logic [POS_W-1:0]   query_end;

  modport source (
    output valid, command, tile_chrom, record_dataset, record_start, record_end,
           query_start, query_end,
    input  ready
  );

  modport sink (
    input  valid, command, tile_chrom, record_dataset, record_start, record_end,
           query_start, query_end,
    output ready
  );
endinterface

interface tios_out_if import tios_pkg::*;;
  logic               valid;
  logic               ready;
  logic               found;
  logic [DS_W-1:0]    hit_dataset;
  logic [POS_W-1:0]   hit_start;
  logic [POS_W-1:0]   hit_end;
  logic [CHROM_W-1:0] hit_chrom;
  logic [NUM_W-1:0]   overlap_number;
  logic               last;

  modport source (
    output valid, found, hit_dataset, hit_start, hit_end, hit_chrom,
           overlap_number, last,
    input  ready
  );

  modport sink (
    input  valid, found, hit_dataset, hit_start, hit_end, hit_chrom,
           overlap_number, last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/tile_interval_overlap_scan_core.sv @@
// ----------------------------------------------------------------------------
// tile_interval_overlap_scan_core
// Overlap search over the region records of one tile, held in a record RAM.
// ----------------------------------------------------------------------------
// The single read port of the record RAM delivers one record per cycle to the
// overlap compare while the result side does not stall. Each hit is held back
// one slot so that the last flag is known when it leaves; back pressure on the
// result channel holds the scan on the current record. No further command is
// taken while a query scans.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_interval_overlap_scan_core import tios_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tios_in_if.sink   in_ch,
  tios_out_if.source out_ch
);

  rec_t store_mem [TILE_DEPTH];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CHROM_W-1:0] chrom_r, chrom_nxt;
  logic [POS_W-1:0]   qs_r, qs_nxt;
  logic [POS_W-1:0]   qe_r, qe_nxt;
  rec_t               rd_data_r;
  logic               dv_r, dv_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [NUM_W-1:0]   hit_num_r, hit_num_nxt;
  logic               pend_v_r, pend_v_nxt;
  rec_t               pend_r, pend_nxt;
  logic [NUM_W-1:0]   pend_num_r, pend_num_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;

  logic             in_acc;
  logic             out_free;
  logic             hit;
  logic             consume;
  logic             scan_last;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  rec_t             wr_rec;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign hit      = !((qs_r > rd_data_r.end_pos) || (qe_r < rd_data_r.start_pos));
  assign consume  = (state_r == ST_SCAN) && dv_r && (!hit || !pend_v_r || out_free);
  assign scan_last = (CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r;

  assign wr_rec.dataset   = in_ch.record_dataset;
  assign wr_rec.start_pos = in_ch.record_start;
  assign wr_rec.end_pos   = in_ch.record_end;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    chrom_nxt     = chrom_r;
    qs_nxt        = qs_r;
    qe_nxt        = qe_r;
    dv_nxt        = dv_r;
    scan_idx_nxt  = scan_idx_r;
    hit_num_nxt   = hit_num_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    pend_num_nxt  = pend_num_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_addr       = scan_idx_r;
    wr_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.command)
            CMD_START: begin
              count_nxt = '0;
              chrom_nxt = in_ch.tile_chrom;
            end
            CMD_APPEND: begin
              if (count_r < CNT_W'(TILE_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              qs_nxt       = in_ch.query_start;
              qe_nxt       = in_ch.query_end;
              rd_addr      = '0;
              scan_idx_nxt = '0;
              hit_num_nxt  = '0;
              pend_v_nxt   = 1'b0;
              dv_nxt       = (count_r != '0);
              state_nxt    = (count_r != '0) ? ST_SCAN : ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (consume) begin
          if (hit) begin
            if (pend_v_r) begin
              out_nxt.found  = 1'b1;
              out_nxt.rec    = pend_r;
              out_nxt.chrom  = chrom_r;
              out_nxt.number = pend_num_r;
              out_nxt.last   = 1'b0;
              out_valid_nxt  = 1'b1;
            end
            pend_v_nxt   = 1'b1;
            pend_nxt     = rd_data_r;
            pend_num_nxt = hit_num_r;
            hit_num_nxt  = hit_num_r + NUM_W'(1);
          end
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          rd_addr      = scan_idx_nxt;
          if (scan_last) begin
            dv_nxt    = 1'b0;
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_nxt.found  = pend_v_r;
          out_nxt.rec    = pend_v_r ? pend_r : '0;
          out_nxt.chrom  = chrom_r;
          out_nxt.number = pend_v_r ? pend_num_r : '0;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count_r[IDX_W-1:0]] <= wr_rec;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      chrom_r     <= '0;
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chrom_r     <= chrom_nxt;
      dv_r        <= dv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qs_r       <= qs_nxt;
    qe_r       <= qe_nxt;
    scan_idx_r <= scan_idx_nxt;
    hit_num_r  <= hit_num_nxt;
    pend_r     <= pend_nxt;
    pend_num_r <= pend_num_nxt;
    out_r      <= out_nxt;
  end

  assign in_ch.ready           = rst_n && (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_r.found;
  assign out_ch.hit_dataset    = out_r.rec.dataset;
  assign out_ch.hit_start      = out_r.rec.start_pos;
  assign out_ch.hit_end        = out_r.rec.end_pos;
  assign out_ch.hit_chrom      = out_r.chrom;
  assign out_ch.overlap_number = out_r.number;
  assign out_ch.last           = out_r.last;

endmodule

`default_nettype wire

@@ rtl/tios_checker.sv @@
// ----------------------------------------------------------------------------
// tios_checker
// Port-level checks on the tile interval overlap scan core.
// ----------------------------------------------------------------------------
`default_nettype none

module tios_checker import tios_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [CMD_W-1:0]   in_command,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_found,
  input wire logic [DS_W-1:0]    out_hit_dataset,
  input wire logic [POS_W-1:0]   out_hit_start,
  input wire logic [POS_W-1:0]   out_hit_end,
  input wire logic [CHROM_W-1:0] out_hit_chrom,
  input wire logic [NUM_W-1:0]   out_overlap_number,
  input wire logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_hit_dataset) && $stable(out_hit_start) && $stable(out_hit_end) &&
      $stable(out_hit_chrom) && $stable(out_overlap_number) && $stable(out_last))
    else $error("result transaction changed while stalled");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_QUERY) |=> !in_ready)
    else $error("command taken right after a query");

  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && (out_overlap_number == '0) &&
      (out_hit_dataset == '0) && (out_hit_start == '0) && (out_hit_end == '0))
    else $error("no-overlap result malformed");

  a_open_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("command taken while a query is still open");

endmodule

bind tile_interval_overlap_scan_core tios_checker u_tios_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_command         (in_ch.command),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_found          (out_ch.found),
  .out_hit_dataset    (out_ch.hit_dataset),
  .out_hit_start      (out_ch.hit_start),
  .out_hit_end        (out_ch.hit_end),
  .out_hit_chrom      (out_ch.hit_chrom),
  .out_overlap_number (out_ch.overlap_number),
  .out_last           (out_ch.last)
);

`default_nettype wire

@@ dv/tile_interval_overlap_scan_core_tb.sv @@
// ----------------------------------------------------------------------------
// tile_interval_overlap_scan_core_tb
// Drives start, append, query and unused command transactions into the scan
// core and predicts every hit transaction from its own copy of the tile
// store. Both channels stall at random. Every hit is checked field by field
// against the oldest prediction, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_interval_overlap_scan_core_tb;
  import tios_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_GAP     = 14;
  localparam int RANDOM_CMDS = 28;
  localparam int DRAIN_WAIT  = 2 * TILE_DEPTH + 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [DS_W-1:0]  DS_MAX  = '1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHROM_W-1:0] tile_chrom;
    logic [DS_W-1:0]    record_dataset;
    logic [POS_W-1:0]   record_start;
    logic [POS_W-1:0]   record_end;
    logic [POS_W-1:0]   query_start;
    logic [POS_W-1:0]   query_end;
  } tile_cmd_t;

  logic clk;
  logic rst_n;

  tios_in_if  in_ch ();
  tios_out_if out_ch ();

  tile_interval_overlap_scan_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rec_t               tile_recs [TILE_DEPTH];
  int                 tile_count;
  logic [CHROM_W-1:0] tile_chrom_now;
  res_t               hits_due [$];

  int  errors;
  int  cycles;
  int  cmds_sent;
  int  random_sent;
  int  queries_sent;
  int  hits_seen;
  int  misses_seen;
  bit  in_calm;
  bit  out_calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d hits still due", $time, cycles,
               hits_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void scan_overlaps(input logic [POS_W-1:0] qs,
                                        input logic [POS_W-1:0] qe);
    res_t scan_q [$];
    res_t r;
    int   n;
    n = 0;
    for (int j = 0; j < tile_count; j++) begin
      if (!(qs > tile_recs[j].end_pos || qe < tile_recs[j].start_pos)) begin
        r.found  = 1'b1;
        r.rec    = tile_recs[j];
        r.chrom  = tile_chrom_now;
        r.number = n[NUM_W-1:0];
        r.last   = 1'b0;
        scan_q.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r        = '0;
      r.chrom  = tile_chrom_now;
      r.last   = 1'b1;
      scan_q.push_back(r);
    end else begin
      r = scan_q.pop_back();
      r.last = 1'b1;
      scan_q.push_back(r);
    end
    foreach (scan_q[k]) hits_due.push_back(scan_q[k]);
  endfunction

  function automatic void apply_command(input tile_cmd_t c);
    case (c.command)
      CMD_START: begin
        tile_count     = 0;
        tile_chrom_now = c.tile_chrom;
      end
      CMD_APPEND: begin
        if (tile_count < TILE_DEPTH) begin
          tile_recs[tile_count] = '{dataset: c.record_dataset,
                                    start_pos: c.record_start,
                                    end_pos: c.record_end};
          tile_count++;
        end
      end
      CMD_QUERY: begin
        scan_overlaps(c.query_start, c.query_end);
        queries_sent++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic tile_cmd_t noise_cmd(input logic [CMD_W-1:0] cmd);
    tile_cmd_t c;
    c.command        = cmd;
    c.tile_chrom     = CHROM_W'($urandom);
    c.record_dataset = DS_W'($urandom);
    c.record_start   = $urandom;
    c.record_end     = $urandom;
    c.query_start    = $urandom;
    c.query_end      = $urandom;
    return c;
  endfunction

  function automatic tile_cmd_t start_cmd(input logic [CHROM_W-1:0] chrom);
    tile_cmd_t c;
    c = noise_cmd(CMD_START);
    c.tile_chrom = chrom;
    return c;
  endfunction

  function automatic tile_cmd_t append_cmd(input logic [DS_W-1:0] ds,
                                           input logic [POS_W-1:0] s,
                                           input logic [POS_W-1:0] e);
    tile_cmd_t c;
    c = noise_cmd(CMD_APPEND);
    c.record_dataset = ds;
    c.record_start   = s;
    c.record_end     = e;
    return c;
  endfunction

  function automatic tile_cmd_t query_cmd(input logic [POS_W-1:0] s,
                                          input logic [POS_W-1:0] e);
    tile_cmd_t c;
    c = noise_cmd(CMD_QUERY);
    c.query_start = s;
    c.query_end   = e;
    return c;
  endfunction

  task automatic send_cmd(input tile_cmd_t c);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.command        <= c.command;
    in_ch.tile_chrom     <= c.tile_chrom;
    in_ch.record_dataset <= c.record_dataset;
    in_ch.record_start   <= c.record_start;
    in_ch.record_end     <= c.record_end;
    in_ch.query_start    <= c.query_start;
    in_ch.query_end      <= c.query_end;
    do @(posedge clk); while (!in_ch.ready);
    apply_command(c);
    cmds_sent++;
  endtask

  // drain ready stalls per hit transaction
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_due.size() == 0) begin
        $display("%0t unexpected hit transaction: found=%0b dataset=%0h start=%0h end=%0h",
                 $time, out_ch.found, out_ch.hit_dataset, out_ch.hit_start,
                 out_ch.hit_end);
        errors++;
      end else begin
        want = hits_due.pop_front();
        check_field("found", want.found, out_ch.found);
        check_field("hit_dataset", want.rec.dataset, out_ch.hit_dataset);
        check_field("hit_start", want.rec.start_pos, out_ch.hit_start);
        check_field("hit_end", want.rec.end_pos, out_ch.hit_end);
        check_field("hit_chrom", want.chrom, out_ch.hit_chrom);
        check_field("overlap_number", want.number, out_ch.overlap_number);
        check_field("last", want.last, out_ch.last);
        if (want.found) hits_seen++;
        else misses_seen++;
      end
    end
  end

  task automatic test_tile_before_start();
    in_calm  = 1'b1;
    out_calm = 1'b1;
    send_cmd(query_cmd(5, 9));
    send_cmd(append_cmd(20'h00007, 5, 9));
    send_cmd(query_cmd(9, 100));
    send_cmd(noise_cmd(CMD_UNUSED));
    send_cmd(query_cmd(10, 100));
  endtask

  task automatic test_field_extremes();
    in_calm  = 1'b0;
    out_calm = 1'b0;
    send_cmd(start_cmd(5'd23));
    send_cmd(append_cmd(DS_MAX, '0, POS_MAX));
    send_cmd(append_cmd('0, POS_MAX, POS_MAX));
    send_cmd(append_cmd(20'h12345, 10, 20));
    send_cmd(append_cmd(20'hABCDE, 100, 50));
    send_cmd(query_cmd('0, '0));
    send_cmd(query_cmd(POS_MAX, POS_MAX));
    send_cmd(query_cmd(20, 30));
    send_cmd(query_cmd(21, 30));
    send_cmd(query_cmd(60, 40));
    send_cmd(noise_cmd(CMD_UNUSED));
    send_cmd(query_cmd(75, 75));
    send_cmd(start_cmd(5'd31));
    send_cmd(query_cmd('0, POS_MAX));
  endtask

  task automatic test_store_full();
    logic [POS_W-1:0] s;
    in_calm  = 1'b1;
    out_calm = 1'b0;
    send_cmd(start_cmd(5'd17));
    for (int i = 0; i < TILE_DEPTH + 2; i++) begin
      s = i * 16;
      send_cmd(append_cmd(DS_W'($urandom), s, s + 15));
      if (i == TILE_DEPTH / 2) in_calm = 1'b0;
    end
    send_cmd(query_cmd('0, POS_MAX));
    send_cmd(query_cmd(100, 300));
    send_cmd(query_cmd(TILE_DEPTH * 16, POS_MAX));
    out_calm = 1'b1;
    send_cmd(query_cmd('0, POS_MAX));
    send_cmd(start_cmd(5'd2));
    send_cmd(query_cmd('0, POS_MAX));
  endtask

  function automatic logic [POS_W-1:0] near_pos(input logic [POS_W-1:0] base,
                                                input int span);
    return base + $urandom_range(0, span);
  endfunction

  task automatic test_random_tiles();
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
    int               span;
    int               n_append;
    int               n_query;
    while (random_sent < RANDOM_CMDS) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      base = $urandom;
      span = 1 << $urandom_range(3, 12);
      if ($urandom_range(0, 9) != 0) begin
        send_cmd(start_cmd(CHROM_W'($urandom)));
        random_sent++;
      end
      n_append = $urandom_range(0, 12);
      n_query  = $urandom_range(1, 4);
      while (n_append + n_query > 0) begin
        if ($urandom_range(0, 15) == 0) begin
          send_cmd(noise_cmd(CMD_UNUSED));
        end else if ($urandom_range(0, 19) == 0) begin
          send_cmd(noise_cmd(CMD_W'($urandom_range(CMD_APPEND, CMD_QUERY))));
          random_sent++;
        end else if (n_append > 0 && ($urandom_range(0, 2) != 0 || n_query == 0)) begin
          s = near_pos(base, span);
          e = ($urandom_range(0, 7) == 0) ? s - $urandom_range(1, span / 4)
                                          : s + $urandom_range(0, span / 4);
          send_cmd(append_cmd(DS_W'($urandom), s, e));
          n_append--;
          random_sent++;
        end else begin
          s = near_pos(base, span);
          e = ($urandom_range(0, 7) == 0) ? s - $urandom_range(1, span / 2)
                                          : s + $urandom_range(0, span / 2);
          send_cmd(query_cmd(s, e));
          n_query--;
          random_sent++;
        end
      end
    end
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    cmds_sent    = 0;
    random_sent  = 0;
    queries_sent = 0;
    hits_seen    = 0;
    misses_seen  = 0;
    in_calm      = 1'b1;
    out_calm     = 1'b1;
    tile_count     = 0;
    tile_chrom_now = '0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_START;
    in_ch.tile_chrom     <= '0;
    in_ch.record_dataset <= '0;
    in_ch.record_start   <= '0;
    in_ch.record_end     <= '0;
    in_ch.query_start    <= '0;
    in_ch.query_end      <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_tile_before_start();
    test_field_extremes();
    test_store_full();
    test_random_tiles();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d command transactions (%0d queries) over %0d cycles.",
             cmds_sent, queries_sent, cycles);
    $display("Checked %0d overlap hits and %0d no-overlap results.",
             hits_seen, misses_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
